// ----- rtl/ddwcs_pkg.sv -----
// shared types, constants and helpers of the wheel command shaper
`default_nettype none

package ddwcs_pkg;

   localparam int CSR_INDEX_W = 8;
   localparam int CSR_DATA_W  = 16;
   localparam int TIMEOUT_W   = 16;
   localparam int MIN_DRIVE_W = 6;
   localparam int ELAPSED_W   = 17;
   localparam int PERCENT_W   = 7;
   localparam int PCT_MAG_W   = 6;

   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_DRIVE = 8'd1;

   localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET   = 16'd1000;
   localparam logic [MIN_DRIVE_W-1:0] MIN_DRIVE_RESET = 6'd20;
   localparam logic [ELAPSED_W-1:0]   ELAPSED_MAX     = 17'd131071;

   // q4.12 thresholds
   localparam int STOP_LIMIT     = 41;
   localparam int SIMILAR_LIMIT  = 614;
   localparam int TURN_SUM_LIMIT = 410;
   localparam int TURN_FULL      = 2070;
   localparam int STRAIGHT_FULL  = 8780;
   localparam int CURVE_FULL     = 4390;

   // reciprocals: floor(a/69) = (a*950)>>16, n/439 ~ (n*38217)>>24, used as 2x and 5x
   localparam int TURN_RECIP     = 950;
   localparam int TURN_SHIFT     = 16;
   localparam int STRAIGHT_RECIP = 76434;
   localparam int CURVE_RECIP    = 191085;
   localparam int DRIVE_SHIFT    = 24;

   localparam logic [PCT_MAG_W-1:0] TURN_MAX_PCT     = 6'd30;
   localparam logic [PCT_MAG_W-1:0] TURN_MIN_PCT     = 6'd15;
   localparam logic [PCT_MAG_W-1:0] STRAIGHT_MAX_PCT = 6'd40;
   localparam logic [PCT_MAG_W-1:0] CURVE_MAX_PCT    = 6'd50;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_TICK    = 2'd1,
      KIND_STOP    = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ACTION_NONE  = 2'd0,
      ACTION_STOP  = 2'd1,
      ACTION_DRIVE = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      MOTION_STOPPED  = 2'd0,
      MOTION_TURN     = 2'd1,
      MOTION_STRAIGHT = 2'd2,
      MOTION_CURVE    = 2'd3
   } motion_type;

   typedef struct packed {
      logic [TIMEOUT_W-1:0]   timeout_ms;
      logic [MIN_DRIVE_W-1:0] min_drive_percent;
   } cfg_type;

   typedef struct packed {
      logic signed [PERCENT_W-1:0] right_drive;
      logic signed [PERCENT_W-1:0] left_drive;
      motion_type                  motion;
   } drive_type;

   function automatic logic [PCT_MAG_W-1:0] raise_min(
      input logic [PCT_MAG_W-1:0] mag,
      input logic [PCT_MAG_W-1:0] floor_pct
   );
      if (mag != '0 && mag < floor_pct) begin
         return floor_pct;
      end
      return mag;
   endfunction

   function automatic logic signed [PERCENT_W-1:0] apply_sign(
      input logic [PCT_MAG_W-1:0] mag,
      input logic                 neg
   );
      logic signed [PERCENT_W-1:0] p;
      p = PERCENT_W'(signed'({1'b0, mag}));
      return neg ? -p : p;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/ddwcs_csr.sv -----
// configuration registers: timeout and minimum drive percent
`default_nettype none

module ddwcs_csr (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [ddwcs_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [ddwcs_pkg::CSR_DATA_W-1:0]    csr_data,
   output ddwcs_pkg::cfg_type                       cfg
);

   logic [ddwcs_pkg::TIMEOUT_W-1:0]   timeout_ff,   timeout_in;
   logic [ddwcs_pkg::MIN_DRIVE_W-1:0] min_drive_ff, min_drive_in;

   assign csr_ready = 1'b1;

   always_comb begin
      timeout_in   = timeout_ff;
      min_drive_in = min_drive_ff;
      if (csr_valid) begin
         unique case (csr_index)
            ddwcs_pkg::CSR_TIMEOUT: begin
               timeout_in = csr_data[ddwcs_pkg::TIMEOUT_W-1:0];
            end
            ddwcs_pkg::CSR_MIN_DRIVE: begin
               min_drive_in = csr_data[ddwcs_pkg::MIN_DRIVE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff   <= ddwcs_pkg::TIMEOUT_RESET;
         min_drive_ff <= ddwcs_pkg::MIN_DRIVE_RESET;
      end else begin
         timeout_ff   <= timeout_in;
         min_drive_ff <= min_drive_in;
      end
   end

   assign cfg.timeout_ms        = timeout_ff;
   assign cfg.min_drive_percent = min_drive_ff;

endmodule

`default_nettype wire

// ----- rtl/ddwcs_shape.sv -----
// command classifier and percent scaling datapath
`default_nettype none

module ddwcs_shape #(
   parameter int VELOCITY_WIDTH = 16
) (
   input  wire logic signed [VELOCITY_WIDTH-1:0]     left_velocity,
   input  wire logic signed [VELOCITY_WIDTH-1:0]     right_velocity,
   input  wire logic [ddwcs_pkg::MIN_DRIVE_W-1:0]    min_drive_percent,
   output logic                                      stopped,
   output ddwcs_pkg::drive_type                      drive
);

   localparam int MAG_W = (VELOCITY_WIDTH + 1 > 16) ? VELOCITY_WIDTH + 1 : 16;
   localparam int EXT_W = MAG_W + 1;

   logic signed [EXT_W-1:0] l_ext, r_ext, sum_ext, diff_ext;
   logic [MAG_W-1:0] l_mag, r_mag, sum_mag, diff_mag;
   logic l_neg, r_neg, l_pos, r_pos, same, straight, in_place;
   logic [ddwcs_pkg::MIN_DRIVE_W-1:0] min_eff;
   logic [21:0] turn_prod;
   logic [31:0] straight_prod, l_curve_prod, r_curve_prod;
   logic [ddwcs_pkg::PCT_MAG_W-1:0] turn_q, turn_pw, straight_q, straight_pw;
   logic [ddwcs_pkg::PCT_MAG_W-1:0] l_curve_q, r_curve_q, l_curve_pw, r_curve_pw;

   assign l_ext    = EXT_W'(left_velocity);
   assign r_ext    = EXT_W'(right_velocity);
   assign sum_ext  = l_ext + r_ext;
   assign diff_ext = l_ext - r_ext;

   assign l_mag    = l_ext[EXT_W-1]    ? MAG_W'(-l_ext)    : MAG_W'(l_ext);
   assign r_mag    = r_ext[EXT_W-1]    ? MAG_W'(-r_ext)    : MAG_W'(r_ext);
   assign sum_mag  = sum_ext[EXT_W-1]  ? MAG_W'(-sum_ext)  : MAG_W'(sum_ext);
   assign diff_mag = diff_ext[EXT_W-1] ? MAG_W'(-diff_ext) : MAG_W'(diff_ext);

   assign l_neg = l_ext[EXT_W-1];
   assign r_neg = r_ext[EXT_W-1];
   assign l_pos = !l_neg && (l_ext != '0);
   assign r_pos = !r_neg && (r_ext != '0);

   assign stopped  = (l_mag < MAG_W'(ddwcs_pkg::STOP_LIMIT))
                  && (r_mag < MAG_W'(ddwcs_pkg::STOP_LIMIT));
   assign same     = (l_pos && r_pos) || (l_neg && r_neg);
   assign straight = same && (diff_mag < MAG_W'(ddwcs_pkg::SIMILAR_LIMIT));
   assign in_place = !same && (sum_mag < MAG_W'(ddwcs_pkg::TURN_SUM_LIMIT));

   assign min_eff = (min_drive_percent > ddwcs_pkg::CURVE_MAX_PCT)
                  ? ddwcs_pkg::CURVE_MAX_PCT : min_drive_percent;

   // in-place turn
   assign turn_prod = 22'(l_mag[11:0]) * 22'(ddwcs_pkg::TURN_RECIP);
   assign turn_q    = turn_prod[ddwcs_pkg::TURN_SHIFT +: ddwcs_pkg::PCT_MAG_W];

   always_comb begin
      if (l_mag >= MAG_W'(ddwcs_pkg::TURN_FULL)) begin
         turn_pw = ddwcs_pkg::TURN_MAX_PCT;
      end else if (turn_q < ddwcs_pkg::TURN_MIN_PCT) begin
         turn_pw = ddwcs_pkg::TURN_MIN_PCT;
      end else begin
         turn_pw = turn_q;
      end
   end

   // straight: sum scaled to +-40
   assign straight_prod = 32'(sum_mag[13:0]) * 32'(ddwcs_pkg::STRAIGHT_RECIP);
   assign straight_q    = straight_prod[ddwcs_pkg::DRIVE_SHIFT +: ddwcs_pkg::PCT_MAG_W];
   assign straight_pw   = ddwcs_pkg::raise_min(
      (sum_mag >= MAG_W'(ddwcs_pkg::STRAIGHT_FULL)) ? ddwcs_pkg::STRAIGHT_MAX_PCT
                                                     : straight_q,
      min_eff);

   // curve: each wheel scaled to +-50
   assign l_curve_prod = 32'(l_mag[12:0]) * 32'(ddwcs_pkg::CURVE_RECIP);
   assign r_curve_prod = 32'(r_mag[12:0]) * 32'(ddwcs_pkg::CURVE_RECIP);
   assign l_curve_q    = l_curve_prod[ddwcs_pkg::DRIVE_SHIFT +: ddwcs_pkg::PCT_MAG_W];
   assign r_curve_q    = r_curve_prod[ddwcs_pkg::DRIVE_SHIFT +: ddwcs_pkg::PCT_MAG_W];
   assign l_curve_pw   = ddwcs_pkg::raise_min(
      (l_mag >= MAG_W'(ddwcs_pkg::CURVE_FULL)) ? ddwcs_pkg::CURVE_MAX_PCT : l_curve_q,
      min_eff);
   assign r_curve_pw   = ddwcs_pkg::raise_min(
      (r_mag >= MAG_W'(ddwcs_pkg::CURVE_FULL)) ? ddwcs_pkg::CURVE_MAX_PCT : r_curve_q,
      min_eff);

   always_comb begin
      if (in_place) begin
         drive.motion      = ddwcs_pkg::MOTION_TURN;
         drive.left_drive  = ddwcs_pkg::apply_sign(turn_pw, l_neg);
         drive.right_drive = ddwcs_pkg::apply_sign(turn_pw, r_neg);
      end else if (straight) begin
         drive.motion      = ddwcs_pkg::MOTION_STRAIGHT;
         drive.left_drive  = ddwcs_pkg::apply_sign(straight_pw, sum_ext[EXT_W-1]);
         drive.right_drive = ddwcs_pkg::apply_sign(straight_pw, sum_ext[EXT_W-1]);
      end else begin
         drive.motion      = ddwcs_pkg::MOTION_CURVE;
         drive.left_drive  = ddwcs_pkg::apply_sign(l_curve_pw, l_neg);
         drive.right_drive = ddwcs_pkg::apply_sign(r_curve_pw, r_neg);
      end
   end

endmodule

`default_nettype wire

// ----- rtl/diff_drive_wheel_command_shaper.sv -----
// top level of the differential-drive wheel command shaper
// Takes one beat per cycle unless stalled: a velocity command, a millisecond tick
// or a stop request (req_tuser), and gives exactly one result beat for each. A beat
// passes an input register, then the classify/scale logic and the halted/elapsed
// update, then the result register, which offers it on rsp_. The sustained rate is
// one beat per cycle while rsp_tready stays high. A stalled result holds the result
// register, and req_tready drops only once the input register is also full.
// Configuration writes on the csr_ channel are always taken and must only be issued
// while no beat is in flight.
`default_nettype none

module diff_drive_wheel_command_shaper #(
   parameter int VELOCITY_WIDTH = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   // left_velocity, right_velocity, zero padding
   input  wire logic [((2*VELOCITY_WIDTH+7)/8)*8-1:0] req_tdata,
   // kind
   input  wire logic [1:0]                        req_tuser,
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   // motion, left_drive, right_drive
   output logic [15:0]                            rsp_tdata,
   // action
   output logic [1:0]                             rsp_tuser,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ddwcs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [ddwcs_pkg::CSR_DATA_W-1:0]  csr_data
);

   ddwcs_pkg::cfg_type   cfg;
   ddwcs_pkg::drive_type drive, drive_zero;
   logic                 stopped;

   logic                             s1_valid_ff, s1_valid_in;
   logic [1:0]                       kind_ff;
   logic signed [VELOCITY_WIDTH-1:0] left_ff, right_ff;

   logic                             rsp_valid_ff, rsp_valid_in;
   ddwcs_pkg::action_type            action_ff, action_in;
   ddwcs_pkg::drive_type             result_ff, result_in;

   logic                             halted_ff, halted_in;
   logic [ddwcs_pkg::ELAPSED_W-1:0]  elapsed_ff, elapsed_in, elapsed_inc;

   logic advance, take, fire;

   ddwcs_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ddwcs_shape #(
      .VELOCITY_WIDTH (VELOCITY_WIDTH)
   ) u_shape (
      .left_velocity     (left_ff),
      .right_velocity    (right_ff),
      .min_drive_percent (cfg.min_drive_percent),
      .stopped           (stopped),
      .drive             (drive)
   );

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || advance;
   assign take       = req_tvalid && req_tready;
   assign fire       = s1_valid_ff && advance;

   assign s1_valid_in  = take ? 1'b1 : (fire ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   assign drive_zero.motion      = ddwcs_pkg::MOTION_STOPPED;
   assign drive_zero.left_drive  = '0;
   assign drive_zero.right_drive = '0;

   assign elapsed_inc = (elapsed_ff != ddwcs_pkg::ELAPSED_MAX)
                      ? elapsed_ff + ddwcs_pkg::ELAPSED_W'(1) : elapsed_ff;

   always_comb begin
      halted_in  = halted_ff;
      elapsed_in = elapsed_ff;
      action_in  = ddwcs_pkg::ACTION_NONE;
      result_in  = drive_zero;
      unique case (kind_ff)
         ddwcs_pkg::KIND_TICK: begin
            elapsed_in = elapsed_inc;
            if (!halted_ff && elapsed_inc > ddwcs_pkg::ELAPSED_W'(cfg.timeout_ms)) begin
               halted_in = 1'b1;
               action_in = ddwcs_pkg::ACTION_STOP;
            end
         end
         ddwcs_pkg::KIND_STOP: begin
            halted_in = 1'b1;
            action_in = ddwcs_pkg::ACTION_STOP;
         end
         ddwcs_pkg::KIND_COMMAND: begin
            elapsed_in = '0;
            if (stopped) begin
               halted_in = 1'b1;
               action_in = ddwcs_pkg::ACTION_STOP;
            end else begin
               halted_in = 1'b0;
               action_in = ddwcs_pkg::ACTION_DRIVE;
               result_in = drive;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         halted_ff    <= 1'b1;
         elapsed_ff   <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            halted_ff  <= halted_in;
            elapsed_ff <= elapsed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= req_tuser;
         left_ff  <= req_tdata[VELOCITY_WIDTH-1:0];
         right_ff <= req_tdata[2*VELOCITY_WIDTH-1:VELOCITY_WIDTH];
      end
      if (fire) begin
         action_ff <= action_in;
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = action_ff;
   assign rsp_tdata  = result_ff;

endmodule

`default_nettype wire
